// ----- rtl/pru_pkg.sv -----
// Shared constants for the pixel row upscaler: default limits, register map,
// result status codes and the row padding function.
// No dependencies.
`default_nettype none

package pru_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_MAX_SCALE = 100;

  localparam int unsigned SCALE_REG_W = 7;
  localparam int unsigned WIDTH_REG_W = 11;
  localparam int unsigned PIX_W       = 24;

  typedef enum logic [0:0] {
    REG_SCALE    = 1'b0,
    REG_IN_WIDTH = 1'b1
  } reg_idx_t;

  localparam logic [1:0] ST_PUSH_OK      = 2'd0;
  localparam logic [1:0] ST_PUSH_REFUSED = 2'd1;
  localparam logic [1:0] ST_PIXEL        = 2'd2;
  localparam logic [1:0] ST_EMPTY        = 2'd3;

  // (4 - (w*s*3 mod 4)) mod 4 depends only on the two low bits of w and s
  function automatic logic [1:0] row_pad(input logic [1:0] w_lo, input logic [1:0] s_lo);
    logic [5:0] prod;
    prod = 6'(w_lo) * 6'(s_lo) * 6'd3;
    return 2'(2'd0 - prod[1:0]);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pixel_row_upscaler_unit.sv -----
// Pixel row upscaler top level: line store memory, replay counters,
// two-stage result pipeline and APB register block.
// Depends on pru_pkg.
`default_nettype none

// Nearest-neighbour integer upscaler for 24-bit pixels.
// Input stream: s_tuser = 0 pushes the pixel on s_tdata into the line store,
// s_tuser = 1 pulls the next output pixel. Every accepted transfer gives one
// result on the output stream: m_tuser is the status, m_tdata the pixel and
// the padding count, m_tlast marks the last pixel of an output row.
// Once in_width pixels have been pushed, the row is replayed: each pixel is
// repeated scale times across and the row scale times down; pushes are
// refused meanwhile and pulls while filling report nothing ready.
// Throughput: one transfer per cycle while s_tready is high, each item using at most
// one access of the line store port (write on push, read on pull).
// Path: each result passes through the stage-1 register and then the output
// register before m_tvalid shows it.
// Receiver stall: up to two results are held in the pipeline, after which
// s_tready drops until m_tready returns.
// Reset: scale 1, width 1, filling an empty row; the line store is not
// cleared and needs no clearing pass. A register write restarts the row.
module pixel_row_upscaler_unit #(
  parameter int unsigned MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  wire logic [0:0]  s_tuser,   // action[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // out_blue, out_green, out_red, pad_bytes[25:24], zero
  output logic [1:0]       m_tuser,   // status[1:0]
  output logic             m_tlast,   // row_end
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CNT_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_WIDTH);
  localparam int unsigned SCALE_W = $clog2(MAX_SCALE + 1);
  localparam int unsigned PIX_W   = pru_pkg::PIX_W;

  logic [pru_pkg::SCALE_REG_W-1:0] scale;
  logic [pru_pkg::WIDTH_REG_W-1:0] in_width;
  logic [CNT_W-1:0]   eff_w;
  logic [SCALE_W-1:0] eff_s;

  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic [CNT_W-1:0]   src_index, src_index_next;
  logic [SCALE_W-1:0] hrep, hrep_next;
  logic [SCALE_W-1:0] rrep, rrep_next;
  logic               replaying, replaying_next;

  logic [PIX_W-1:0] line_store [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data;
  logic             wr_en, rd_en;

  logic             s1_valid;
  logic [1:0]       s1_status, s1_status_next;
  logic [1:0]       s1_pad, s1_pad_next;
  logic             s1_end, s1_end_next;
  logic             s1_adv;

  logic             out_valid;
  logic [1:0]       out_status;
  logic [PIX_W-1:0] out_pix;
  logic [1:0]       out_pad;
  logic             out_end;

  logic acc, cfg_wr, pull;

  // effective limits
  always_comb begin
    if (in_width == '0) begin
      eff_w = CNT_W'(1);
    end else if (32'(in_width) > 32'(MAX_WIDTH)) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = CNT_W'(in_width);
    end
    if (scale == '0) begin
      eff_s = SCALE_W'(1);
    end else if (32'(scale) > 32'(MAX_SCALE)) begin
      eff_s = SCALE_W'(MAX_SCALE);
    end else begin
      eff_s = SCALE_W'(scale);
    end
  end

  // handshake
  assign s1_adv   = !out_valid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign acc      = s_tvalid && s_tready;
  assign pull     = s_tuser[0];
  assign cfg_wr   = psel && penable && pwrite && pready;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= pru_pkg::SCALE_REG_W'(1);
      in_width <= pru_pkg::WIDTH_REG_W'(1);
    end else if (cfg_wr) begin
      case (pru_pkg::reg_idx_t'(paddr[2]))
        pru_pkg::REG_SCALE:    scale    <= pwdata[pru_pkg::SCALE_REG_W-1:0];
        pru_pkg::REG_IN_WIDTH: in_width <= pwdata[pru_pkg::WIDTH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pru_pkg::reg_idx_t'(paddr[2]))
      pru_pkg::REG_SCALE:    prdata = 32'(scale);
      pru_pkg::REG_IN_WIDTH: prdata = 32'(in_width);
      default:               prdata = '0;
    endcase
  end

  // row control
  always_comb begin
    fill_count_next = fill_count;
    src_index_next  = src_index;
    hrep_next       = hrep;
    rrep_next       = rrep;
    replaying_next  = replaying;
    s1_status_next  = pru_pkg::ST_EMPTY;
    s1_pad_next     = '0;
    s1_end_next     = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    if (!pull) begin
      if (replaying) begin
        s1_status_next = pru_pkg::ST_PUSH_REFUSED;
      end else begin
        s1_status_next = pru_pkg::ST_PUSH_OK;
        wr_en          = acc;
        if (CNT_W'(fill_count + 1'b1) == eff_w) begin
          fill_count_next = '0;
          src_index_next  = '0;
          hrep_next       = '0;
          rrep_next       = '0;
          replaying_next  = 1'b1;
        end else begin
          fill_count_next = CNT_W'(fill_count + 1'b1);
        end
      end
    end else if (replaying) begin
      s1_status_next = pru_pkg::ST_PIXEL;
      rd_en          = acc;
      if (SCALE_W'(hrep + 1'b1) == eff_s) begin
        hrep_next = '0;
        if (CNT_W'(src_index + 1'b1) == eff_w) begin
          src_index_next = '0;
          s1_end_next    = 1'b1;
          s1_pad_next    = pru_pkg::row_pad(eff_w[1:0], eff_s[1:0]);
          if (SCALE_W'(rrep + 1'b1) == eff_s) begin
            rrep_next      = '0;
            replaying_next = 1'b0;
          end else begin
            rrep_next = SCALE_W'(rrep + 1'b1);
          end
        end else begin
          src_index_next = CNT_W'(src_index + 1'b1);
        end
      end else begin
        hrep_next = SCALE_W'(hrep + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      fill_count <= '0;
      src_index  <= '0;
      hrep       <= '0;
      rrep       <= '0;
      replaying  <= 1'b0;
    end else if (acc) begin
      fill_count <= fill_count_next;
      src_index  <= src_index_next;
      hrep       <= hrep_next;
      rrep       <= rrep_next;
      replaying  <= replaying_next;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[fill_count[ADDR_W-1:0]] <= s_tdata;
    end
    if (rd_en) begin
      rd_data <= line_store[src_index[ADDR_W-1:0]];
    end
  end

  // stage 1: waiting on store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= acc;
    end
    if (acc) begin
      s1_status <= s1_status_next;
      s1_pad    <= s1_pad_next;
      s1_end    <= s1_end_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      out_status <= s1_status;
      out_pix    <= (s1_status == pru_pkg::ST_PIXEL) ? rd_data : '0;
      out_pad    <= s1_pad;
      out_end    <= s1_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_end;
  assign m_tdata  = {6'b0, out_pad, out_pix};

`ifndef SYNTH
  a_fill_idle_in_replay: assert property (@(posedge clk) disable iff (rst)
    replaying |-> fill_count == '0)
    else $error("fill count nonzero during replay");

  a_counters_bounded: assert property (@(posedge clk) disable iff (rst)
    hrep < eff_s && rrep < eff_s && src_index < eff_w && fill_count < eff_w)
    else $error("row counter out of range");

  a_end_is_pixel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == pru_pkg::ST_PIXEL)
    else $error("row end on non-pixel result");

  a_pad_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25:24] != 2'd0 |-> m_tlast)
    else $error("padding outside row end");

  a_no_store_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("store written and read in one cycle");
`endif

endmodule

`default_nettype wire

// ----- sim/pru_checker.sv -----
// Scoreboard for the pixel row upscaler: keeps its own copy of the line store,
// replay counters and registers, predicts one result per input transfer and
// compares it with the output stream. Depends on pru_pkg; holds pru_tb_pkg.
`timescale 1ns / 100ps

package pru_tb_pkg;

  typedef enum logic [0:0] {
    ACT_PUSH = 1'b0,
    ACT_PULL = 1'b1
  } pru_action_t;

  function automatic int unsigned eff_scale(input logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > pru_pkg::DEF_MAX_SCALE) return pru_pkg::DEF_MAX_SCALE;
    return raw;
  endfunction

  function automatic int unsigned eff_width(input logic [10:0] raw);
    if (raw == 0) return 1;
    if (raw > pru_pkg::DEF_MAX_WIDTH) return pru_pkg::DEF_MAX_WIDTH;
    return raw;
  endfunction

endpackage

module pru_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned results_owed
);
  import pru_pkg::*;
  import pru_tb_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic       row_end;
    logic [5:0] spare;
    logic [1:0] pad;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } px_result_t;

  logic [PIX_W-1:0]       row_buf [DEF_MAX_WIDTH];
  logic [SCALE_REG_W-1:0] cfg_scale;
  logic [WIDTH_REG_W-1:0] cfg_width;
  int unsigned            fill_cnt, src_idx, h_rep, v_rep;
  bit                     replaying;
  px_result_t             owed_px [$];

  function automatic void restart_row();
    fill_cnt  = 0;
    src_idx   = 0;
    h_rep     = 0;
    v_rep     = 0;
    replaying = 1'b0;
  endfunction

  function automatic px_result_t upscale_step(input pru_action_t act, input logic [23:0] px);
    px_result_t  res;
    int unsigned w, s;
    res = '0;
    w = eff_width(cfg_width);
    s = eff_scale(cfg_scale);
    if (act == ACT_PUSH) begin
      if (replaying) begin
        res.status = ST_PUSH_REFUSED;
      end else begin
        row_buf[fill_cnt] = px;
        fill_cnt++;
        if (fill_cnt >= w) begin
          restart_row();
          replaying = 1'b1;
        end
        res.status = ST_PUSH_OK;
      end
    end else if (!replaying) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = ST_PIXEL;
      {res.red, res.green, res.blue} = row_buf[src_idx];
      h_rep++;
      if (h_rep >= s) begin
        h_rep = 0;
        src_idx++;
        if (src_idx >= w) begin
          src_idx     = 0;
          res.row_end = 1'b1;
          res.pad     = 2'((4 - (w * s * 3) % 4) % 4);
          v_rep++;
          if (v_rep >= s) begin
            v_rep     = 0;
            replaying = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    px_result_t  got, want;
    logic [31:0] reg_val;
    if (rst) begin
      cfg_scale = SCALE_REG_W'(1);
      cfg_width = WIDTH_REG_W'(1);
      restart_row();
      owed_px.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_SCALE) cfg_scale = pwdata[SCALE_REG_W-1:0];
          else cfg_width = pwdata[WIDTH_REG_W-1:0];
          restart_row();
        end else begin
          reg_val = (paddr[2] == REG_SCALE) ? 32'(cfg_scale) : 32'(cfg_width);
          if (prdata !== reg_val) begin
            mismatches++;
            $display("%0t: register read at %0d: expected %h, got %h",
                     $time, paddr, reg_val, prdata);
          end
        end
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tlast, m_tdata};
        if (owed_px.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: got status %0d last %b data %h",
                   $time, got.status, got.row_end, got[31:0]);
        end else begin
          want = owed_px.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected status %0d last %b data %h, got status %0d last %b data %h",
                     $time, want.status, want.row_end, want[31:0],
                     got.status, got.row_end, got[31:0]);
          end
        end
      end
      if (s_tvalid && s_tready)
        owed_px.push_back(upscale_step(pru_action_t'(s_tuser), s_tdata));
    end
    results_owed <= owed_px.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the pixel row upscaler regression: clock, reset, stream and APB
// stimulus with random idling, and the final verdict.
// Depends on pru_pkg, pru_tb_pkg and pru_checker (sim/pru_checker.sv).
`timescale 1ns / 100ps

module testbench;
  import pru_pkg::*;
  import pru_tb_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int unsigned mismatches;
  int unsigned results_owed;

  bit          calm = 1'b0;
  logic [6:0]  scale_raw = 7'd1;
  logic [10:0] width_raw = 11'd1;
  int unsigned item_count = 0;

  pixel_row_upscaler_unit dut (.*);
  pru_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("pixel_row_upscaler_unit regression: fail");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int unsigned stall;
    @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = calm ? 0 : idle_len();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  task automatic pause();
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stream_item(input pru_action_t act, input logic [23:0] px);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    item_count++;
    pause();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic reg_access(input logic wr, input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write with random upper bits, then read back
  task automatic configure(input reg_idx_t idx, input logic [10:0] raw);
    logic [31:0] value;
    drain();
    value = $urandom;
    if (idx == REG_SCALE) begin
      value[6:0] = raw[6:0];
      scale_raw  = raw[6:0];
    end else begin
      value[10:0] = raw;
      width_raw   = raw;
    end
    reg_access(1'b1, idx, value);
    reg_access(1'b0, idx, $urandom);
  endtask

  // pushes then pulls, with stray pulls while filling and stray pushes in replay
  task automatic run_row(input int unsigned fill_n, input int unsigned pull_n,
                         input int unsigned noise_pct);
    for (int unsigned i = 0; i < fill_n; i++) begin
      if ($urandom_range(99) < noise_pct) stream_item(ACT_PULL, 24'($urandom));
      stream_item(ACT_PUSH, 24'($urandom));
    end
    for (int unsigned i = 0; i < pull_n; i++) begin
      if ($urandom_range(99) < noise_pct) stream_item(ACT_PUSH, 24'($urandom));
      stream_item(ACT_PULL, 24'($urandom));
    end
  endtask

  initial begin
    int unsigned s_eff, w_eff, w_cap, rows;
    logic [6:0]  s_new;
    logic [10:0] w_new;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stream_item(ACT_PULL, 24'h000000);
    stream_item(ACT_PUSH, 24'h000000);
    stream_item(ACT_PUSH, 24'hFFFFFF);
    stream_item(ACT_PULL, 24'hFFFFFF);
    stream_item(ACT_PULL, 24'h5A5A5A);
    configure(REG_SCALE, 11'd2);
    configure(REG_IN_WIDTH, 11'd3);
    stream_item(ACT_PUSH, 24'hFFFFFF);
    stream_item(ACT_PUSH, 24'h000000);
    stream_item(ACT_PUSH, 24'hA5C30F);
    repeat (12) stream_item(ACT_PULL, 24'h000000);
    configure(REG_SCALE, 11'd0);
    configure(REG_IN_WIDTH, 11'd0);
    stream_item(ACT_PUSH, 24'h0F3CA5);
    stream_item(ACT_PULL, 24'hFFFFFF);

    // extremes, with no idling
    calm = 1'b1;
    configure(REG_SCALE, 11'd127);
    configure(REG_IN_WIDTH, 11'd1);
    run_row(1, 120, 1);
    configure(REG_SCALE, 11'd100);
    run_row(1, 110, 1);
    configure(REG_SCALE, 11'd1);
    configure(REG_IN_WIDTH, 11'd2047);
    run_row(40, 0, 1);

    while (item_count < 700) begin
      calm  = ($urandom_range(3) == 0);
      s_new = ($urandom_range(7) == 0) ? 7'd0 : 7'($urandom_range(1, 8));
      s_eff = eff_scale(s_new);
      w_cap = 200 / (s_eff * s_eff);
      if ($urandom_range(3) == 0 && eff_width(width_raw) <= w_cap) begin
        configure(REG_SCALE, 11'(s_new));
      end else begin
        if ($urandom_range(7) == 0) w_new = 11'd0;
        else if ($urandom_range(4) == 0) w_new = 11'($urandom_range(1, w_cap));
        else w_new = 11'($urandom_range(1, (w_cap < 12) ? w_cap : 12));
        if ($urandom_range(1)) begin
          configure(REG_SCALE, 11'(s_new));
          configure(REG_IN_WIDTH, w_new);
        end else begin
          configure(REG_IN_WIDTH, w_new);
          configure(REG_SCALE, 11'(s_new));
        end
      end
      w_eff = eff_width(width_raw);
      s_eff = eff_scale(scale_raw);
      rows  = $urandom_range(1, 3);
      repeat (rows) begin
        run_row(w_eff, w_eff * s_eff * s_eff, 8);
        if ($urandom_range(4) == 0) drain();
      end
      // now and then leave a row partly done so the next write has to abort it
      case ($urandom_range(2))
        1: run_row($urandom_range(w_eff - 1), 0, 8);
        2: run_row(w_eff, $urandom_range(w_eff * s_eff * s_eff - 1), 8);
        default: ;
      endcase
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("pixel_row_upscaler_unit regression: pass");
    else $display("pixel_row_upscaler_unit regression: fail");
    $finish;
  end

endmodule
